@@ src/ntc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntc_pkg: shared types, constants and curve table
// Thermistor curve points, datapath widths and the job word passed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
package ntc_pkg;

   localparam int TABLE_POINTS = 19;
   localparam int IDX_W        = 5;
   localparam int CODE_W       = 12;
   localparam int TEMP_W       = 12;
   localparam int OHM_W        = 19;   // whole ohms of a curve point
   localparam int NUM_W        = 29;   // 108900 * code
   localparam int DEN_W        = 18;   // 204750 - 33 * code
   localparam int RES_W        = 29;   // resistance, Q16, below 8192 ohms
   localparam int DIFF_W       = 35;   // (hi - r) in Q16
   localparam int FRAC_W       = 17;   // fraction, 0 .. 65536
   localparam int SPAN_W       = 18;
   localparam int DIV1_STEPS   = RES_W;
   localparam int DIV2_STEPS   = FRAC_W;

   localparam logic [CODE_W-1:0] LIMIT_RESET = 12'd4000;
   localparam logic [16:0]       NUM_K       = 17'd108900;
   localparam logic [DEN_W-1:0]  DEN_BASE    = 18'd204750;
   localparam logic [DEN_W-1:0]  DEN_K       = 18'd33;

   typedef struct packed {
      logic              sat;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } ntc_job_type;

   function automatic logic [OHM_W-1:0] point_ohms(input logic [IDX_W-1:0] idx);
      logic [OHM_W-1:0] v;
      unique case (idx)
         5'd0:  v = 19'd402000;
         5'd1:  v = 19'd200000;
         5'd2:  v = 19'd105000;
         5'd3:  v = 19'd58200;
         5'd4:  v = 19'd33660;
         5'd5:  v = 19'd20200;
         5'd6:  v = 19'd12500;
         5'd7:  v = 19'd10000;
         5'd8:  v = 19'd8040;
         5'd9:  v = 19'd5300;
         5'd10: v = 19'd3590;
         5'd11: v = 19'd2490;
         5'd12: v = 19'd1760;
         5'd13: v = 19'd1270;
         5'd14: v = 19'd934;
         5'd15: v = 19'd638;
         5'd16: v = 19'd529;
         5'd17: v = 19'd198;
         5'd18: v = 19'd74;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [TEMP_W-1:0] point_temp(input logic [IDX_W-1:0] idx);
      logic signed [TEMP_W-1:0] v;
      unique case (idx)
         5'd0:  v = -12'sd400;
         5'd1:  v = -12'sd300;
         5'd2:  v = -12'sd200;
         5'd3:  v = -12'sd100;
         5'd4:  v = 12'sd0;
         5'd5:  v = 12'sd100;
         5'd6:  v = 12'sd200;
         5'd7:  v = 12'sd250;
         5'd8:  v = 12'sd300;
         5'd9:  v = 12'sd400;
         5'd10: v = 12'sd500;
         5'd11: v = 12'sd600;
         5'd12: v = 12'sd700;
         5'd13: v = 12'sd800;
         5'd14: v = 12'sd900;
         5'd15: v = 12'sd1000;
         5'd16: v = 12'sd1100;
         5'd17: v = 12'sd1500;
         5'd18: v = 12'sd2000;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ src/ntc_adc_to_temperature.sv @@
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature: NTC thermistor ADC code to temperature
// Converts 12-bit divider samples to tenths of a degree by table interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_sample and raise start; the word is taken at a clock edge
//   where start is high and busy is low. busy only rises if the internal
//   queue backs up, which the free-running back end never lets happen, so
//   one word can be taken every cycle.
//   Each result appears for exactly one cycle with rsp_strobe high, carrying
//   rsp_temperature_decidegrees (signed tenths of a degree, 0 when invalid)
//   and rsp_valid_res. Results come out in order; the receiver cannot stall
//   them, so capture them on the strobe.
//   The strobe is high after the accepting edge has passed through the front
//   register, the queue, the divider load, 29 steps of the resistance divider,
//   a table search stage, 17 steps of the fraction divider, a multiply and a
//   rounding stage. Throughput is one word per cycle, set by the fully
//   pipelined dividers.
//   csr_we writes csr_wdata to the saturation limit; write it only while idle.
//   Synchronous reset empties the pipeline and restores a limit of 4000.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_adc_to_temperature (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [ntc_pkg::CODE_W-1:0]           req_sample,
   output logic                                      rsp_strobe,
   output logic signed [ntc_pkg::TEMP_W-1:0]         rsp_temperature_decidegrees,
   output logic                                      rsp_valid_res,
   input  wire logic                                 csr_we,
   input  wire logic [ntc_pkg::CODE_W-1:0]           csr_wdata
);

   logic                 accept;
   logic                 front_valid;
   ntc_pkg::ntc_job_type front_job;
   logic                 q_valid;
   ntc_pkg::ntc_job_type q_job;
   logic                 q_almost_full;

   // take a word only when the queue has room for it
   assign accept = start && !busy;
   assign busy   = q_almost_full;

   ntc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .sample    (req_sample),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .job_valid (front_valid),
      .job       (front_job)
   );

   // back end always drains, so pop whenever something is queued
   ntc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (front_valid),
      .push_job    (front_job),
      .pop_ready   (1'b1),
      .pop_valid   (q_valid),
      .pop_job     (q_job),
      .almost_full (q_almost_full)
   );

   ntc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_valid),
      .job        (q_job),
      .rsp_strobe (rsp_strobe),
      .rsp_temp   (rsp_temperature_decidegrees),
      .rsp_valid  (rsp_valid_res)
   );

endmodule
`default_nettype wire

@@ src/ntc_front.sv @@
// ----------------------------------------------------------------------------
// ntc_front: accept and classify codes
// Holds the saturation limit, flags saturated codes and forms the divider
// numerator and denominator.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [ntc_pkg::CODE_W-1:0]    sample,
   input  wire logic                          csr_we,
   input  wire logic [ntc_pkg::CODE_W-1:0]    csr_wdata,
   output logic                               job_valid,
   output ntc_pkg::ntc_job_type               job
);

   logic [ntc_pkg::CODE_W-1:0] limit_ff;
   logic                       valid_ff;
   ntc_pkg::ntc_job_type       job_ff, job_in;

   always_comb begin
      job_in.sat = (sample >= limit_ff);
      job_in.num = {12'd0, ntc_pkg::NUM_K} * {17'd0, sample};
      job_in.den = ntc_pkg::DEN_BASE - ntc_pkg::DEN_K * {6'd0, sample};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ntc_pkg::LIMIT_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         valid_ff <= accept;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule
`default_nettype wire

@@ src/ntc_queue.sv @@
// ----------------------------------------------------------------------------
// ntc_queue: short job queue
// Four-entry queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  ntc_pkg::ntc_job_type     push_job,
   input  wire logic                pop_ready,
   output logic                     pop_valid,
   output ntc_pkg::ntc_job_type     pop_job,
   output logic                     almost_full
);

   ntc_pkg::ntc_job_type mem [0:3];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       pop;

   assign pop_valid   = (count_ff != 3'd0);
   assign pop         = pop_valid && pop_ready;
   assign pop_job     = mem[rd_ptr_ff];
   assign almost_full = (count_ff >= 3'd3);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         if (push && !pop)      count_ff <= count_ff + 3'd1;
         else if (pop && !push) count_ff <= count_ff - 3'd1;
      end
   end

endmodule
`default_nettype wire

@@ src/ntc_back.sv @@
// ----------------------------------------------------------------------------
// ntc_back: resistance, table lookup and interpolation
// Pipelined restoring divider for resistance, segment search, pipelined
// divider for the fraction, multiply and rounding.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   input  ntc_pkg::ntc_job_type                      job,
   output logic                                      rsp_strobe,
   output logic signed [ntc_pkg::TEMP_W-1:0]         rsp_temp,
   output logic                                      rsp_valid
);

   localparam int S1 = ntc_pkg::DIV1_STEPS;
   localparam int S2 = ntc_pkg::DIV2_STEPS;

   // resistance divider stages
   logic                         d1_v_ff   [0:S1];
   logic                         d1_sat_ff [0:S1];
   logic [ntc_pkg::DEN_W-1:0]    d1_rem_ff [0:S1];
   logic [ntc_pkg::DEN_W-1:0]    d1_den_ff [0:S1];
   logic [ntc_pkg::RES_W-1:0]    d1_bit_ff [0:S1];
   logic [ntc_pkg::RES_W-1:0]    d1_q_ff   [0:S1];

   // fraction divider stages
   logic                         d2_v_ff    [0:S2];
   logic                         d2_ok_ff   [0:S2];
   logic [ntc_pkg::SPAN_W-1:0]   d2_rem_ff  [0:S2];
   logic [ntc_pkg::SPAN_W-1:0]   d2_span_ff [0:S2];
   logic [ntc_pkg::FRAC_W-1:0]   d2_bit_ff  [0:S2];
   logic [ntc_pkg::FRAC_W-1:0]   d2_q_ff    [0:S2];
   logic signed [ntc_pkg::TEMP_W-1:0] d2_t0_ff [0:S2];
   logic signed [ntc_pkg::TEMP_W-1:0] d2_dt_ff [0:S2];

   // classify stage
   logic [ntc_pkg::RES_W-1:0]    r;
   logic [ntc_pkg::IDX_W-1:0]    seg;
   logic                         in_range;
   logic [ntc_pkg::OHM_W-1:0]    hi_ohms, lo_ohms;
   logic [ntc_pkg::DIFF_W-1:0]   diff;

   // multiply and round
   logic                         m_v_ff, m_ok_ff;
   logic signed [29:0]           m_prod_ff;
   logic signed [ntc_pkg::TEMP_W-1:0] m_t0_ff;
   logic signed [30:0]           scaled;
   logic signed [30:0]           rounded;
   logic                         out_v_ff, out_ok_ff;
   logic signed [ntc_pkg::TEMP_W-1:0] out_t_ff, out_t_in;

   assign r = d1_q_ff[S1];

   always_comb begin
      seg = '0;
      for (int j = ntc_pkg::TABLE_POINTS - 1; j >= 1; j--) begin
         if ({6'd0, r} >= {ntc_pkg::point_ohms(ntc_pkg::IDX_W'(j)), 16'd0}) begin
            seg = ntc_pkg::IDX_W'(j - 1);
         end
      end
      in_range = ({6'd0, r} >= {ntc_pkg::point_ohms(
                     ntc_pkg::IDX_W'(ntc_pkg::TABLE_POINTS - 1)), 16'd0}) &&
                 ({6'd0, r} <= {ntc_pkg::point_ohms('0), 16'd0});
      hi_ohms = ntc_pkg::point_ohms(seg);
      lo_ohms = ntc_pkg::point_ohms(seg + 5'd1);
      diff    = {hi_ohms, 16'd0} - {6'd0, r};
   end

   always_ff @(posedge clock) begin
      // load resistance divider: top quotient bits are known zero
      d1_sat_ff[0] <= job.sat;
      d1_den_ff[0] <= job.den;
      d1_rem_ff[0] <= {2'd0, job.num[28:13]};
      d1_bit_ff[0] <= {job.num[12:0], 16'd0};
      d1_q_ff[0]   <= '0;
      for (int k = 0; k < S1; k++) begin : g_d1
         d1_sat_ff[k+1] <= d1_sat_ff[k];
         d1_den_ff[k+1] <= d1_den_ff[k];
         d1_bit_ff[k+1] <= d1_bit_ff[k] << 1;
         if ({d1_rem_ff[k], d1_bit_ff[k][ntc_pkg::RES_W-1]} >= {1'b0, d1_den_ff[k]}) begin
            d1_rem_ff[k+1] <= ntc_pkg::DEN_W'({d1_rem_ff[k], d1_bit_ff[k][ntc_pkg::RES_W-1]}
                                              - {1'b0, d1_den_ff[k]});
            d1_q_ff[k+1]   <= {d1_q_ff[k][ntc_pkg::RES_W-2:0], 1'b1};
         end else begin
            d1_rem_ff[k+1] <= d1_rem_ff[k][ntc_pkg::DEN_W-1:0] << 1
                              | {17'd0, d1_bit_ff[k][ntc_pkg::RES_W-1]};
            d1_q_ff[k+1]   <= {d1_q_ff[k][ntc_pkg::RES_W-2:0], 1'b0};
         end
      end

      // classify and load fraction divider
      d2_ok_ff[0]   <= !d1_sat_ff[S1] && in_range;
      d2_span_ff[0] <= ntc_pkg::SPAN_W'(hi_ohms - lo_ohms);
      d2_rem_ff[0]  <= diff[34:17];
      d2_bit_ff[0]  <= diff[16:0];
      d2_q_ff[0]    <= '0;
      d2_t0_ff[0]   <= ntc_pkg::point_temp(seg);
      d2_dt_ff[0]   <= ntc_pkg::point_temp(seg + 5'd1) - ntc_pkg::point_temp(seg);
      for (int k = 0; k < S2; k++) begin : g_d2
         d2_ok_ff[k+1]   <= d2_ok_ff[k];
         d2_span_ff[k+1] <= d2_span_ff[k];
         d2_t0_ff[k+1]   <= d2_t0_ff[k];
         d2_dt_ff[k+1]   <= d2_dt_ff[k];
         d2_bit_ff[k+1]  <= d2_bit_ff[k] << 1;
         if ({d2_rem_ff[k], d2_bit_ff[k][ntc_pkg::FRAC_W-1]} >= {1'b0, d2_span_ff[k]}) begin
            d2_rem_ff[k+1] <= ntc_pkg::SPAN_W'({d2_rem_ff[k], d2_bit_ff[k][ntc_pkg::FRAC_W-1]}
                                               - {1'b0, d2_span_ff[k]});
            d2_q_ff[k+1]   <= {d2_q_ff[k][ntc_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            d2_rem_ff[k+1] <= d2_rem_ff[k] << 1
                              | {17'd0, d2_bit_ff[k][ntc_pkg::FRAC_W-1]};
            d2_q_ff[k+1]   <= {d2_q_ff[k][ntc_pkg::FRAC_W-2:0], 1'b0};
         end
      end

      // multiply fraction by temperature step
      m_ok_ff   <= d2_ok_ff[S2];
      m_t0_ff   <= d2_t0_ff[S2];
      m_prod_ff <= $signed(30'({1'b0, d2_q_ff[S2]})) * 30'(d2_dt_ff[S2]);

      out_ok_ff <= m_ok_ff;
      out_t_ff  <= out_t_in;
   end

   always_comb begin
      scaled = $signed({{3{m_t0_ff[ntc_pkg::TEMP_W-1]}}, m_t0_ff, 16'd0}) +
               31'(m_prod_ff);
      if (scaled >= 0) begin
         rounded = (scaled + 31'sd32768) >>> 16;
      end else begin
         rounded = -((-scaled + 31'sd32768) >>> 16);
      end
      out_t_in = m_ok_ff ? ntc_pkg::TEMP_W'(rounded) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= S1; k++) d1_v_ff[k] <= 1'b0;
         for (int k = 0; k <= S2; k++) d2_v_ff[k] <= 1'b0;
         m_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         d1_v_ff[0] <= job_valid;
         for (int k = 0; k < S1; k++) d1_v_ff[k+1] <= d1_v_ff[k];
         d2_v_ff[0] <= d1_v_ff[S1];
         for (int k = 0; k < S2; k++) d2_v_ff[k+1] <= d2_v_ff[k];
         m_v_ff   <= d2_v_ff[S2];
         out_v_ff <= m_v_ff;
      end
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_temp   = out_t_ff;
   assign rsp_valid  = out_ok_ff;

endmodule
`default_nettype wire

@@ src/ntc_checker.sv @@
// ----------------------------------------------------------------------------
// ntc_checker: port-level checks
// Watches the result port of the converter.
// ----------------------------------------------------------------------------
`default_nettype none
module ntc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_strobe,
   input wire logic signed [ntc_pkg::TEMP_W-1:0]  rsp_temperature_decidegrees,
   input wire logic                               rsp_valid_res
);

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |-> rsp_temperature_decidegrees == '0)
      else $error("invalid result with nonzero temperature");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_valid_res |->
         rsp_temperature_decidegrees >= -12'sd400 &&
         rsp_temperature_decidegrees <= 12'sd2000)
      else $error("temperature outside curve range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

bind ntc_adc_to_temperature ntc_checker u_ntc_checker (
   .clock                       (clock),
   .reset                       (reset),
   .rsp_strobe                  (rsp_strobe),
   .rsp_temperature_decidegrees (rsp_temperature_decidegrees),
   .rsp_valid_res               (rsp_valid_res)
);
`default_nettype wire

@@ tb/sv/ntc_adc_to_temperature_tb.sv @@
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_tb: self-checking bench for the NTC converter
// Drives ADC code words with random idle gaps, predicts each temperature from
// an independent divider/interpolation model and checks every strobed result
// in order. The saturation limit is changed between phases while idle.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW           = ntc_pkg::CODE_W;
   localparam int TW           = ntc_pkg::TEMP_W;
   localparam int NPTS         = ntc_pkg::TABLE_POINTS;
   localparam int DRAIN_CYCLES = 80;
   localparam int WATCHDOG_MAX = 5000;

   typedef struct {
      logic signed [TW-1:0] temp;
      logic                 ok;
   } reading_type;

   // Scoreboard: holds the expected readings in issue order.
   class reading_board;
      reading_type   pending[$];
      int            errors;
      logic [CW-1:0] limit;

      function new();
         errors = 0;
         limit  = ntc_pkg::LIMIT_RESET;
      endfunction

      // Convert a code to the expected reading under the current limit.
      function reading_type convert(logic [CW-1:0] code);
         longint unsigned ohm[NPTS] = '{402000, 200000, 105000, 58200, 33660,
            20200, 12500, 10000, 8040, 5300, 3590, 2490, 1760, 1270, 934, 638, 529,
            198, 74};
         longint        deg[NPTS] = '{-400, -300, -200, -100, 0, 100, 200, 250,
            300, 400, 500, 600, 700, 800, 900, 1000, 1100, 1500, 2000};
         longint unsigned r, hi, lo, span;
         longint        frac, scaled, t;
         reading_type   res;
         res.temp = '0;
         res.ok   = 1'b0;
         if (code >= limit) return res;
         r = ((longint'(108900) * code) << 16) / (204750 - 33 * longint'(code));
         if (r > (ohm[0] << 16) || r < (ohm[NPTS-1] << 16)) return res;
         for (int i = 0; i + 1 < NPTS; i++) begin
            hi = ohm[i] << 16;
            lo = ohm[i+1] << 16;
            if (r <= hi && r >= lo) begin
               span   = ohm[i] - ohm[i+1];
               frac   = longint'((hi - r) / span);
               scaled = deg[i] * 65536 + frac * (deg[i+1] - deg[i]);
               // round half away from zero
               if (scaled >= 0) t = (scaled + 32768) / 65536;
               else t = -((-scaled + 32768) / 65536);
               res.temp = t[TW-1:0];
               res.ok   = 1'b1;
               return res;
            end
         end
         return res;
      endfunction

      function void note_code(logic [CW-1:0] code);
         pending.push_back(convert(code));
      endfunction

      function void check_reading(logic signed [TW-1:0] temp, logic ok);
         reading_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word temp=%0d valid=%0b", $time, temp, ok);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (temp !== want.temp) begin
            $display("%0t: temperature expected %0d actual %0d", $time, want.temp, temp);
            errors++;
         end
         if (ok !== want.ok) begin
            $display("%0t: valid expected %0b actual %0b", $time, want.ok, ok);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CW-1:0] req_sample = '0;
   logic rsp_strobe;
   logic signed [TW-1:0] rsp_temperature_decidegrees;
   logic rsp_valid_res;
   logic csr_we = 1'b0;
   logic [CW-1:0] csr_wdata = '0;

   reading_board board = new();
   int idle_pct = 0;     // sender idle chance in percent
   int quiet = 0;        // cycles since the last accepted word or result

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ntc_adc_to_temperature u_dut (
      .clock                       (clock),
      .reset                       (reset),
      .start                       (start),
      .busy                        (busy),
      .req_sample                  (req_sample),
      .rsp_strobe                  (rsp_strobe),
      .rsp_temperature_decidegrees (rsp_temperature_decidegrees),
      .rsp_valid_res               (rsp_valid_res),
      .csr_we                      (csr_we),
      .csr_wdata                   (csr_wdata)
   );

   // Monitor: check results and note accepted words at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            board.check_reading(rsp_temperature_decidegrees, rsp_valid_res);
         end
         if (start && !busy) begin
            board.note_code(req_sample);
         end
         if (rsp_strobe || (start && !busy)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet >= WATCHDOG_MAX) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Send one code word, idling first at random; hold start until taken.
   task automatic send_code(logic [CW-1:0] code);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_sample <= code;
      @(posedge clock iff !busy);
   endtask

   // Drain the pipeline, then write the limit while idle.
   task automatic set_limit(logic [CW-1:0] value);
      wait_drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.limit = value;
      @(posedge clock);
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random code: mostly spread, some near the table ends and the limit.
   function automatic logic [CW-1:0] pick_code();
      int sel;
      sel = int'($urandom_range(9));
      if (sel < 6) return CW'($urandom_range(4095));
      if (sel == 6) return CW'($urandom_range(60));
      if (sel == 7) return CW'($urandom_range(4095, 3900));
      if (sel == 8 && board.limit > 3) return board.limit - CW'($urandom_range(3));
      return board.limit;
   endfunction

   initial begin
      int dir_codes[$] = '{0, 1, 4095, 2048, 4, 5, 6, 7, 3998, 3999, 4000, 4001,
         1365, 2730, 3500, 3000, 100, 50, 2500, 1000};
      int phase_idle[4] = '{0, 73, 0, 28};
      int limits[4] = '{4095, 0, 3000, 4000};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, table ends, limit boundary.
      foreach (dir_codes[i]) send_code(CW'(dir_codes[i]));
      set_limit(12'd0);          // every code saturates
      send_code(12'd0);
      send_code(12'd4095);
      set_limit(12'd4095);
      send_code(12'd4094);
      send_code(12'd4095);
      send_code(12'hAAA);
      send_code(12'h555);

      // Random phases with different limits and idle rates.
      for (int p = 0; p < 4; p++) begin
         set_limit(CW'(limits[p]));
         idle_pct = phase_idle[p];
         for (int n = 0; n < 420; n++) begin
            send_code(pick_code());
            if (p == 2 && n == 200) wait_drain();   // hold off until empty
         end
      end

      wait_drain();
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
src/ntc_pkg.sv
src/ntc_front.sv
src/ntc_queue.sv
src/ntc_back.sv
src/ntc_adc_to_temperature.sv
src/ntc_checker.sv
tb/sv/ntc_adc_to_temperature_tb.sv
